// ===== rtl/intc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package intc_pkg;

  // Number of implemented interrupt sources, 1 to 32.
  localparam int NUM_SOURCES = 32;

  // Width of a bus data word.
  localparam int DATA_W = 32;

  // Mask of the state bits that exist for the implemented sources.
  localparam logic [DATA_W-1:0] SRC_MASK = {DATA_W{1'b1}} >> (DATA_W - NUM_SOURCES);

  // Command codes of an input beat.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_READ  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_LINE  = 2'd2;

  // Register word offsets.
  typedef logic [2:0] offset_t;
  localparam offset_t OFF_STATUS   = 3'd0;
  localparam offset_t OFF_ENABLE   = 3'd1;
  localparam offset_t OFF_SET      = 3'd2;
  localparam offset_t OFF_CLEAR    = 3'd3;
  localparam offset_t OFF_POLARITY = 3'd4;
  localparam offset_t OFF_EDGE     = 3'd5;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [4:0]        src_idx_t;

endpackage

`default_nettype wire

// ===== rtl/intc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one bus access or source line change per beat.
interface intc_req_if
  import intc_pkg::*;
();
  logic     valid;
  logic     ready;
  cmd_t     command;
  offset_t  reg_offset;
  word_t    write_data;
  src_idx_t source_index;
  logic     source_level;

  modport source (
    output valid, command, reg_offset, write_data, source_index, source_level,
    input  ready
  );

  modport sink (
    input  valid, command, reg_offset, write_data, source_index, source_level,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/intc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Response channel: read data and CPU request per beat.
interface intc_rsp_if
  import intc_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t read_data;
  logic  cpu_request;

  modport source (
    output valid, read_data, cpu_request,
    input  ready
  );

  modport sink (
    input  valid, read_data, cpu_request,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/intc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module intc_core
  import intc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  intc_req_if.sink    req,
  intc_rsp_if.source  rsp
);

  // Input register.
  logic     s1_valid;
  cmd_t     s1_command;
  offset_t  s1_offset;
  word_t    s1_data;
  src_idx_t s1_index;
  logic     s1_level;

  // Controller state.
  word_t pending;
  word_t enable;
  word_t polarity;
  word_t edge_mode;

  word_t pending_next;
  word_t enable_next;
  word_t polarity_next;
  word_t edge_mode_next;
  word_t read_value;
  word_t wdata;
  word_t line_bit;
  logic  line_valid;
  logic  s1_fire;

  assign s1_fire   = s1_valid && rsp.ready;
  assign req.ready = !s1_valid || rsp.ready;

  // Capture an accepted beat; the register frees up once its result moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_command <= req.command;
      s1_offset  <= req.reg_offset;
      s1_data    <= req.write_data;
      s1_index   <= req.source_index;
      s1_level   <= req.source_level;
    end
  end

  // Next state and read data for the beat held in the input register.
  always_comb begin
    wdata          = s1_data & SRC_MASK;
    line_bit       = word_t'(1) << s1_index;
    line_valid     = {1'b0, s1_index} < 6'(NUM_SOURCES);
    pending_next   = pending;
    enable_next    = enable;
    polarity_next  = polarity;
    edge_mode_next = edge_mode;
    read_value     = '0;
    case (s1_command)
      CMD_READ: begin
        case (s1_offset)
          OFF_STATUS:   read_value = pending & enable;
          OFF_ENABLE:   read_value = enable;
          OFF_POLARITY: read_value = polarity;
          OFF_EDGE:     read_value = edge_mode;
          default:      read_value = '0;
        endcase
      end
      CMD_WRITE: begin
        case (s1_offset)
          OFF_STATUS:   pending_next   = wdata;
          OFF_ENABLE:   enable_next    = wdata;
          OFF_SET:      enable_next    = enable | wdata;
          OFF_CLEAR:    pending_next   = pending & ~(wdata & edge_mode);
          OFF_POLARITY: polarity_next  = wdata;
          OFF_EDGE:     edge_mode_next = wdata;
          default:      ;
        endcase
      end
      CMD_LINE: begin
        if (line_valid) begin
          if (s1_level) begin
            pending_next = (pending | line_bit) & SRC_MASK;
          end else begin
            pending_next = pending & (~line_bit | edge_mode) & SRC_MASK;
          end
        end
      end
      default: ;
    endcase
  end

  // State update when the result beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      enable    <= '0;
      polarity  <= '0;
      edge_mode <= '0;
    end else if (s1_fire) begin
      pending   <= pending_next;
      enable    <= enable_next;
      polarity  <= polarity_next;
      edge_mode <= edge_mode_next;
    end
  end

  assign rsp.valid       = s1_valid;
  assign rsp.read_data   = read_value;
  assign rsp.cpu_request = |(pending_next & enable_next);

`ifndef NO_ASSERTIONS
  // The reported request matches the state that the beat leaves behind.
  a_request_matches_state: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> (|(pending & enable)) == $past(rsp.cpu_request))
    else $error("cpu_request disagrees with stored state");

  // A bus read leaves every state word unchanged.
  a_read_no_side_effect: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_command == CMD_READ |=>
      $stable(pending) && $stable(enable) && $stable(polarity) && $stable(edge_mode))
    else $error("bus read changed state");

  // Only reads return data.
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_command != CMD_READ |-> rsp.read_data == '0)
    else $error("non-read beat returned data");

  // No state bit exists above the implemented sources.
  a_pending_masked: assert property (@(posedge clk) disable iff (rst)
    (pending & ~SRC_MASK) == '0)
    else $error("pending bit set for unimplemented source");
`endif

endmodule

`default_nettype wire

// ===== rtl/intc_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module intc_skid
  import intc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  intc_rsp_if.sink   up,
  intc_rsp_if.source dn
);

  // Output register and skid entry.
  logic  main_valid;
  word_t main_data;
  logic  main_req;
  logic  skid_valid;
  word_t skid_data;
  logic  skid_req;

  logic push;
  logic pop;

  assign up.ready = !skid_valid;
  assign push     = up.valid && !skid_valid;
  assign pop      = main_valid && dn.ready;

  // Fill the output register first; park a beat in the skid when it is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push && (!main_valid || pop)) begin
      main_valid <= 1'b1;
    end else if (push) begin
      skid_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
    if (skid_valid && pop) begin
      main_data <= skid_data;
      main_req  <= skid_req;
    end else if (push && (!main_valid || pop)) begin
      main_data <= up.read_data;
      main_req  <= up.cpu_request;
    end
    if (push && main_valid && !pop) begin
      skid_data <= up.read_data;
      skid_req  <= up.cpu_request;
    end
  end

  assign dn.valid       = main_valid;
  assign dn.read_data   = main_data;
  assign dn.cpu_request = main_req;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever used behind a full output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry valid with empty output register");
`endif

endmodule

`default_nettype wire

// ===== rtl/interrupt_controller_32src.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 32-source interrupt controller with edge and level modes.
//
// The req channel takes one beat per bus read, bus write or source line
// change; the rsp channel returns exactly one beat for each, in order, with
// the read data (zero for anything but a read) and the CPU request as it
// stands after that beat.
//
// A request beat is held in an input register, where the register update and
// the result are formed by plain bitwise logic, and the result then sits in
// an output register. Throughput is one beat per cycle while the receiver
// keeps taking rsp beats.
//
// A two-entry output buffer (output register plus skid entry) keeps req.ready
// high while one result waits; when the receiver stalls long enough the
// buffer fills and req.ready drops until rsp beats are taken again.
//
// Synchronous reset clears pending, enable, polarity and edge words to zero
// and empties the input register and output buffer.

module interrupt_controller_32src
  import intc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  intc_req_if.sink   req,
  intc_rsp_if.source rsp
);

  intc_rsp_if core_rsp ();

  intc_core u_core (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (core_rsp.source)
  );

  intc_skid u_skid (
    .clk (clk),
    .rst (rst),
    .up  (core_rsp.sink),
    .dn  (rsp)
  );

endmodule

`default_nettype wire

// ===== sim/interrupt_controller_32src_tb.sv =====
`timescale 1ns / 1ps

module interrupt_controller_32src_tb;
  import intc_pkg::*;

  // Codes that the package leaves unnamed.
  localparam cmd_t    CMD_NONE      = 2'd3;
  localparam offset_t OFF_SPARE_LO  = 3'd6;
  localparam offset_t OFF_SPARE_HI  = 3'd7;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    cmd_t     command;
    offset_t  reg_offset;
    word_t    write_data;
    src_idx_t source_index;
    logic     source_level;
  } intc_beat_t;

  typedef struct packed {
    word_t read_data;
    logic  cpu_request;
  } intc_result_t;

  logic clk;
  logic rst;

  intc_req_if req_ch ();
  intc_rsp_if rsp_ch ();

  interrupt_controller_32src dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the controller's register words.
  word_t pend_word;
  word_t enab_word;
  word_t pol_word;
  word_t edge_word;

  intc_result_t expected_q[$];

  int idle_pct;
  int stall_pct;
  int beats_sent;
  int results_seen;
  int request_high_seen;
  int mismatch_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one beat to the shadow registers and return the result it yields.
  function automatic intc_result_t predict_beat(input intc_beat_t b);
    intc_result_t res;
    word_t        data;
    word_t        bit_mask;
    res.read_data = '0;
    data = b.write_data & SRC_MASK;
    case (b.command)
      CMD_READ: begin
        case (b.reg_offset)
          OFF_STATUS:   res.read_data = pend_word & enab_word;
          OFF_ENABLE:   res.read_data = enab_word;
          OFF_POLARITY: res.read_data = pol_word;
          OFF_EDGE:     res.read_data = edge_word;
          default:      res.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (b.reg_offset)
          OFF_STATUS:   pend_word = data;
          OFF_ENABLE:   enab_word = data;
          OFF_SET:      enab_word = enab_word | data;
          OFF_CLEAR:    pend_word = pend_word & ~(data & edge_word);
          OFF_POLARITY: pol_word = data;
          OFF_EDGE:     edge_word = data;
          default:      ;
        endcase
      end
      CMD_LINE: begin
        if (int'(b.source_index) < NUM_SOURCES) begin
          bit_mask = word_t'(1) << b.source_index;
          if (b.source_level) begin
            pend_word = pend_word | bit_mask;
          end else begin
            // Only level-mode sources drop their pending bit.
            pend_word = pend_word & (~bit_mask | edge_word);
          end
          pend_word = pend_word & SRC_MASK;
        end
      end
      default: ;
    endcase
    res.cpu_request = |(pend_word & enab_word);
    return res;
  endfunction

  // Receiver side: stall at the rate of the current phase.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    intc_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (rsp_ch.cpu_request) request_high_seen++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing expected: read_data %h cpu_request %b",
                 $time, rsp_ch.read_data, rsp_ch.cpu_request);
      end else begin
        want = expected_q.pop_front();
        if (rsp_ch.read_data !== want.read_data) begin
          mismatch_count++;
          $display("%0t: read_data expected %h actual %h",
                   $time, want.read_data, rsp_ch.read_data);
        end
        if (rsp_ch.cpu_request !== want.cpu_request) begin
          mismatch_count++;
          $display("%0t: cpu_request expected %b actual %b",
                   $time, want.cpu_request, rsp_ch.cpu_request);
        end
      end
    end
  end

  // Send one request beat, with a random gap ahead of it, and record its result.
  task automatic send_beat(input intc_beat_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= b.command;
    req_ch.reg_offset   <= b.reg_offset;
    req_ch.write_data   <= b.write_data;
    req_ch.source_index <= b.source_index;
    req_ch.source_level <= b.source_level;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_q.push_back(predict_beat(b));
    beats_sent++;
  endtask

  task automatic send_access(input cmd_t c, input offset_t off, input word_t data);
    intc_beat_t b;
    b.command      = c;
    b.reg_offset   = off;
    b.write_data   = data;
    b.source_index = src_idx_t'($urandom_range(31));
    b.source_level = 1'($urandom_range(1));
    send_beat(b);
  endtask

  task automatic send_line(input src_idx_t idx, input logic level);
    intc_beat_t b;
    b.command      = CMD_LINE;
    b.reg_offset   = offset_t'($urandom_range(7));
    b.write_data   = $urandom;
    b.source_index = idx;
    b.source_level = level;
    send_beat(b);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every word reads back zero after reset, spare offsets included.
  task automatic test_reset_state();
    for (int off = 0; off < 8; off++) begin
      send_access(CMD_READ, offset_t'(off), $urandom);
    end
  endtask

  // Each register offset with extreme data, including the spare ones.
  task automatic test_register_map();
    send_access(CMD_WRITE, OFF_ENABLE,   32'hFFFF_FFFF);
    send_access(CMD_WRITE, OFF_STATUS,   32'hFFFF_FFFF);
    send_access(CMD_READ,  OFF_STATUS,   32'h0);
    send_access(CMD_WRITE, OFF_EDGE,     32'h5555_5555);
    send_access(CMD_WRITE, OFF_CLEAR,    32'hFFFF_FFFF);
    send_access(CMD_READ,  OFF_STATUS,   32'h0);
    send_access(CMD_WRITE, OFF_POLARITY, 32'hFFFF_FFFF);
    send_access(CMD_READ,  OFF_POLARITY, 32'h0);
    send_access(CMD_WRITE, OFF_ENABLE,   32'h0);
    send_access(CMD_WRITE, OFF_SET,      32'h8000_0001);
    send_access(CMD_READ,  OFF_ENABLE,   32'h0);
    send_access(CMD_WRITE, OFF_SPARE_LO, 32'hFFFF_FFFF);
    send_access(CMD_READ,  OFF_SPARE_LO, 32'h0);
    send_access(CMD_WRITE, OFF_SPARE_HI, 32'hFFFF_FFFF);
    send_access(CMD_READ,  OFF_SPARE_HI, 32'h0);
  endtask

  // Level and edge behavior on the outermost sources, and the unused command.
  task automatic test_line_events();
    intc_beat_t b;
    send_line(5'd31, 1'b1);
    send_line(5'd31, 1'b0);
    send_line(5'd0,  1'b1);
    send_line(5'd0,  1'b0);
    b.command      = CMD_NONE;
    b.reg_offset   = OFF_STATUS;
    b.write_data   = 32'hFFFF_FFFF;
    b.source_index = 5'd0;
    b.source_level = 1'b0;
    send_beat(b);
  endtask

  // Random beat, weighted toward meaningful register traffic and line activity.
  function automatic intc_beat_t make_random_beat();
    intc_beat_t b;
    int roll;
    int shape;
    roll = $urandom_range(99);
    shape = $urandom_range(4);
    b.reg_offset   = offset_t'($urandom_range(7));
    b.write_data   = $urandom;
    b.source_index = src_idx_t'($urandom_range(31));
    b.source_level = 1'($urandom_range(1));
    if (roll < 40) begin
      b.command = CMD_LINE;
    end else if (roll < 70) begin
      b.command = CMD_READ;
    end else if (roll < 96) begin
      b.command = CMD_WRITE;
      if ($urandom_range(9) != 0) b.reg_offset = offset_t'($urandom_range(5));
      case (shape)
        0: b.write_data = word_t'(1) << $urandom_range(31);
        1: b.write_data = 32'hFFFF_FFFF;
        2: b.write_data = 32'h0;
        default: ;
      endcase
    end else begin
      b.command = CMD_NONE;
    end
    return b;
  endfunction

  task automatic test_random(input int idle, input int stall, input int count);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      send_beat(make_random_beat());
    end
  endtask

  // Main sequence.
  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_READ;
    req_ch.reg_offset   <= OFF_STATUS;
    req_ch.write_data   <= '0;
    req_ch.source_index <= '0;
    req_ch.source_level <= 1'b0;
    pend_word = '0;
    enab_word = '0;
    pol_word  = '0;
    edge_word = '0;
    idle_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    results_seen = 0;
    request_high_seen = 0;
    mismatch_count = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_register_map();
    test_line_events();
    wait_for_drain();

    test_random(0, 0, 200);
    test_random(56, 0, 200);
    wait_for_drain();
    test_random(0, 56, 200);
    test_random(20, 20, 200);
    wait_for_drain();

    if (expected_q.size() != 0) mismatch_count++;

    $display("Sent %0d request beats: reads, writes to all offsets, line changes, unused command.",
             beats_sent);
    $display("Checked %0d result beats, %0d with cpu_request high, under both stall kinds.",
             results_seen, request_high_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
